// File: hdl/tcs_pkg.sv
// shared types, constants and arithmetic helpers for the triangle geometry stage
`timescale 1ns / 1ps
`default_nettype none
package tcs_pkg;

  typedef logic signed [31:0] word_t;

  typedef enum logic [2:0] {
    REG_PROJ_X    = 3'd0,
    REG_PROJ_Y    = 3'd1,
    REG_PROJ_Z    = 3'd2,
    REG_PROJ_ZOFF = 3'd3,
    REG_SCREEN_W  = 3'd4,
    REG_SCREEN_H  = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TRI  = 1'b1
  } action_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } vec3_t;

  typedef word_t mat_t [16];

  typedef struct packed {
    word_t x_scale;
    word_t y_scale;
    word_t z_scale;
    word_t z_offset;
  } proj_cfg_t;

  typedef struct packed {
    logic       keep;
    logic [3:0] level;
  } face_res_t;

  localparam word_t ONE_Q16  = 32'sd65536;
  localparam word_t WORD_MAX = 32'sh7fffffff;
  localparam word_t WORD_MIN = 32'sh80000000;

  localparam word_t PROJ_X_RESET    = 32'sd61167;
  localparam word_t PROJ_Y_RESET    = 32'sd65536;
  localparam word_t PROJ_Z_RESET    = 32'sd65543;
  localparam word_t PROJ_ZOFF_RESET = -32'sd6554;
  localparam logic [12:0] SCREEN_W_RESET = 13'd300;
  localparam logic [12:0] SCREEN_H_RESET = 13'd280;

  localparam int unsigned DIV_BITS   = 48;
  localparam int unsigned FACE_LAT   = 10;
  localparam int unsigned LANE_LAT   = 55;
  localparam int unsigned FACE_DELAY = LANE_LAT - FACE_LAT;

  // floor(n/3) = (n * magic) >> 33 for n < 2^33
  localparam logic [31:0] DIV3_MAGIC = 32'd2863311531;
  localparam int unsigned DIV3_SHIFT = 33;

  localparam int unsigned SHADE_LEVELS = 13;

  function automatic word_t sat32(input logic signed [63:0] v);
    word_t r;
    if (v > 64'sd2147483647) begin
      r = WORD_MAX;
    end else if (v < -64'sd2147483648) begin
      r = WORD_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // q16.16 product floored by 2^16
  function automatic logic signed [47:0] qmul(input word_t a, input word_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 48'(p >>> 16);
  endfunction

  // right shift needed to bring a value into [-2^24, 2^24)
  function automatic logic [4:0] norm_shift(input logic signed [48:0] v);
    logic [5:0] width;
    width = 6'd1;
    for (int i = 0; i < 48; i++) begin
      if (v[i] != v[48]) width = 6'(i + 2);
    end
    return (width > 6'd25) ? 5'(width - 6'd25) : 5'd0;
  endfunction

endpackage
`default_nettype wire

// File: hdl/tcs_div.sv
// pipelined signed divider: trunc(num * 2^16 / den), saturating, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module tcs_div (
  input  logic                clk,
  input  logic                adv,
  input  tcs_pkg::word_t      num,
  input  tcs_pkg::word_t      den,
  output tcs_pkg::word_t      quo
);

  typedef struct packed {
    logic neg;
    logic wzero;
    logic pneg;
    logic pzero;
  } div_flag_t;

  logic [31:0]                      rem [tcs_pkg::DIV_BITS+1];
  logic [tcs_pkg::DIV_BITS-1:0]     nq  [tcs_pkg::DIV_BITS+1];
  logic [31:0]                      dv  [tcs_pkg::DIV_BITS+1];
  div_flag_t                        fl  [tcs_pkg::DIV_BITS+1];
  logic [31:0]                      pmag;
  logic [31:0]                      wmag;
  logic [tcs_pkg::DIV_BITS-1:0]     qmag;

  assign pmag = num[31] ? 32'(-num) : num;
  assign wmag = den[31] ? 32'(-den) : den;

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= '0;
      nq[0]  <= {pmag, 16'b0};
      dv[0]  <= wmag;
      fl[0]  <= '{neg: num[31] ^ den[31], wzero: (den == '0), pneg: num[31],
                  pzero: (num == '0)};
    end
  end

  for (genvar i = 0; i < tcs_pkg::DIV_BITS; i++) begin : g_step
    logic [32:0] t;
    logic        ge;
    assign t  = {rem[i], nq[i][tcs_pkg::DIV_BITS-1]};
    assign ge = (t >= {1'b0, dv[i]});
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i+1] <= ge ? 32'(t - {1'b0, dv[i]}) : t[31:0];
        nq[i+1]  <= {nq[i][tcs_pkg::DIV_BITS-2:0], ge};
        dv[i+1]  <= dv[i];
        fl[i+1]  <= fl[i];
      end
    end
  end

  assign qmag = nq[tcs_pkg::DIV_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fl[tcs_pkg::DIV_BITS].wzero) begin
        if (fl[tcs_pkg::DIV_BITS].pzero) begin
          quo <= '0;
        end else if (fl[tcs_pkg::DIV_BITS].pneg) begin
          quo <= tcs_pkg::WORD_MIN;
        end else begin
          quo <= tcs_pkg::WORD_MAX;
        end
      end else if (fl[tcs_pkg::DIV_BITS].neg) begin
        quo <= (qmag > 48'h0000_8000_0000) ? tcs_pkg::WORD_MIN : 32'(-qmag[31:0]);
      end else begin
        quo <= (qmag > 48'h0000_7fff_ffff) ? tcs_pkg::WORD_MAX : qmag[31:0];
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/tcs_lane.sv
// one vertex lane: world transform, projection, divide by w and screen scaling
`timescale 1ns / 1ps
`default_nettype none
module tcs_lane (
  input  logic                clk,
  input  logic                adv,
  input  tcs_pkg::vec3_t      vin,
  input  tcs_pkg::mat_t       world,
  input  tcs_pkg::proj_cfg_t  proj,
  input  logic [12:0]         screen_w,
  input  logic [12:0]         screen_h,
  output tcs_pkg::vec3_t      tv,
  output tcs_pkg::word_t      sx,
  output tcs_pkg::word_t      sy,
  output tcs_pkg::word_t      qz
);

  tcs_pkg::word_t       in_c [3];
  logic signed [47:0]   prod [3][4];
  tcs_pkg::word_t       trow [4];
  tcs_pkg::word_t       tvw  [4];
  logic signed [47:0]   pp   [4];
  tcs_pkg::word_t       w3;
  tcs_pkg::word_t       px;
  tcs_pkg::word_t       py;
  tcs_pkg::word_t       pz;
  tcs_pkg::word_t       w4;
  tcs_pkg::word_t       qx;
  tcs_pkg::word_t       qy;
  tcs_pkg::word_t       qzd;

  assign in_c[0] = vin.x;
  assign in_c[1] = vin.y;
  assign in_c[2] = vin.z;

  // row vector times matrix, each product floored on its own
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod[r][c] <= tcs_pkg::qmul(in_c[r], world[4*r+c]);
        end
      end
      for (int c = 0; c < 4; c++) begin
        trow[c] <= world[12+c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        tvw[c] <= tcs_pkg::sat32(64'(prod[0][c]) + 64'(prod[1][c]) + 64'(prod[2][c])
                                 + 64'(trow[c]));
      end
    end
  end

  assign tv = '{x: tvw[0], y: tvw[1], z: tvw[2]};

  always_ff @(posedge clk) begin
    if (adv) begin
      pp[0] <= tcs_pkg::qmul(tvw[0], proj.x_scale);
      pp[1] <= tcs_pkg::qmul(tvw[1], proj.y_scale);
      pp[2] <= tcs_pkg::qmul(tvw[2], proj.z_scale);
      pp[3] <= tcs_pkg::qmul(tvw[3], proj.z_offset);
      w3    <= tvw[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px <= tcs_pkg::sat32(64'(pp[0]));
      py <= tcs_pkg::sat32(64'(pp[1]));
      pz <= tcs_pkg::sat32(64'(pp[2]) + 64'(pp[3]));
      w4 <= w3;
    end
  end

  tcs_div u_div_x (.clk(clk), .adv(adv), .num(px), .den(w4), .quo(qx));
  tcs_div u_div_y (.clk(clk), .adv(adv), .num(py), .den(w4), .quo(qy));
  tcs_div u_div_z (.clk(clk), .adv(adv), .num(pz), .den(w4), .quo(qzd));

  // (q + 1.0) * size / 2, floored
  always_ff @(posedge clk) begin
    if (adv) begin
      sx <= tcs_pkg::sat32(((64'(qx) + 64'(tcs_pkg::ONE_Q16))
                            * 64'(signed'({1'b0, screen_w}))) >>> 1);
      sy <= tcs_pkg::sat32(((64'(qy) + 64'(tcs_pkg::ONE_Q16))
                            * 64'(signed'({1'b0, screen_h}))) >>> 1);
      qz <= qzd;
    end
  end

endmodule
`default_nettype wire

// File: hdl/tcs_face.sv
// face normal, back-face test and flat shade level from the three transformed vertices
`timescale 1ns / 1ps
`default_nettype none
module tcs_face (
  input  logic                clk,
  input  logic                adv,
  input  tcs_pkg::vec3_t      v0,
  input  tcs_pkg::vec3_t      v1,
  input  tcs_pkg::vec3_t      v2,
  output tcs_pkg::face_res_t  res
);

  tcs_pkg::word_t        e1 [3];
  tcs_pkg::word_t        e2 [3];
  tcs_pkg::vec3_t        a3, a4, a5, a6, a7;
  logic signed [47:0]    cp [6];
  logic signed [48:0]    nr5 [3];
  logic signed [48:0]    nr6 [3];
  logic [4:0]            sh6;
  logic [4:0]            sh_max;
  logic signed [24:0]    n7 [3];
  logic signed [56:0]    dp8 [3];
  logic [49:0]           sq8 [3];
  logic                  tpos8;
  logic signed [58:0]    dsum;
  logic                  keep9;
  logic [51:0]           nn9;
  logic [49:0]           tt9;
  logic                  tpos9;
  logic [59:0]           tt169;
  logic [59:0]           nn60;
  logic [3:0]            lvl;

  always_ff @(posedge clk) begin
    if (adv) begin
      e1[0] <= tcs_pkg::sat32(64'(v1.x) - 64'(v0.x));
      e1[1] <= tcs_pkg::sat32(64'(v1.y) - 64'(v0.y));
      e1[2] <= tcs_pkg::sat32(64'(v1.z) - 64'(v0.z));
      e2[0] <= tcs_pkg::sat32(64'(v2.x) - 64'(v0.x));
      e2[1] <= tcs_pkg::sat32(64'(v2.y) - 64'(v0.y));
      e2[2] <= tcs_pkg::sat32(64'(v2.z) - 64'(v0.z));
      a3    <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cp[0] <= tcs_pkg::qmul(e1[1], e2[2]);
      cp[1] <= tcs_pkg::qmul(e1[2], e2[1]);
      cp[2] <= tcs_pkg::qmul(e1[2], e2[0]);
      cp[3] <= tcs_pkg::qmul(e1[0], e2[2]);
      cp[4] <= tcs_pkg::qmul(e1[0], e2[1]);
      cp[5] <= tcs_pkg::qmul(e1[1], e2[0]);
      a4    <= a3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nr5[0] <= 49'(cp[0]) - 49'(cp[1]);
      nr5[1] <= 49'(cp[2]) - 49'(cp[3]);
      nr5[2] <= 49'(cp[4]) - 49'(cp[5]);
      a5     <= a4;
    end
  end

  // one shift for all three components, the largest one sets it
  always_comb begin
    logic [4:0] s;
    sh_max = '0;
    for (int j = 0; j < 3; j++) begin
      s = tcs_pkg::norm_shift(nr5[j]);
      if (s > sh_max) sh_max = s;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sh6 <= sh_max;
      nr6 <= nr5;
      a6  <= a5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        n7[j] <= 25'(nr6[j] >>> sh6);
      end
      a7 <= a6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dp8[0] <= 57'(n7[0]) * 57'(a7.x);
      dp8[1] <= 57'(n7[1]) * 57'(a7.y);
      dp8[2] <= 57'(n7[2]) * 57'(a7.z);
      for (int j = 0; j < 3; j++) begin
        sq8[j] <= 50'(50'(n7[j]) * 50'(n7[j]));
      end
      tpos8 <= n7[2][24];
    end
  end

  assign dsum = 59'(dp8[0]) + 59'(dp8[1]) + 59'(dp8[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      keep9 <= dsum[58];
      nn9   <= 52'(sq8[0]) + 52'(sq8[1]) + 52'(sq8[2]);
      tt9   <= sq8[2];
      tpos9 <= tpos8;
    end
  end

  // largest k with k^2 |n|^2 <= 169 t^2, with 13 reported as 0; dim faces clamp to level 1
  assign tt169 = 60'(tt9) * 60'd169;
  assign nn60  = 60'(nn9);

  always_comb begin
    lvl = 4'd1;
    if (tpos9 && !((60'(tt9) * 60'd100) < nn60)) begin
      for (int k = 2; k <= tcs_pkg::SHADE_LEVELS; k++) begin
        if ((60'(k * k) * nn60) <= tt169) lvl = 4'(k);
      end
    end
    if (lvl == 4'(tcs_pkg::SHADE_LEVELS)) lvl = 4'd0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= '{keep: keep9, level: lvl};
    end
  end

endmodule
`default_nettype wire

// File: hdl/triangle_transform_cull_shade.sv
// top level: matrix store, three vertex lanes, face unit and output merge
`timescale 1ns / 1ps
`default_nettype none
// Takes one item per clock while the pipeline is not held; kept triangles leave
// after the lane, merge and output registers. Most of the delay lies in the 48-stage
// divider in each vertex lane, one quotient bit per stage. Load items (tuser 0) write
// one world matrix entry as they are accepted; triangles accepted afterwards use it.
// Triangle items (tuser 1) that face away from the camera or are degenerate produce
// no output. The whole pipeline holds while the output register is full and not
// taken. Configuration writes take effect at once and belong only in idle periods.
module triangle_transform_cull_shade (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // matrix_index, matrix_value, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero pad
  input  logic [327:0]  s_tdata,
  // action
  input  logic          s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // screen_ax, screen_ay, screen_bx, screen_by, screen_cx, screen_cy, mean_depth,
  // shade_level, zero pad
  output logic [231:0]  m_tdata,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  logic                    adv;
  logic                    accept;
  tcs_pkg::proj_cfg_t      proj;
  logic [12:0]             screen_w;
  logic [12:0]             screen_h;
  tcs_pkg::mat_t           world;
  tcs_pkg::vec3_t          in_a, in_b, in_c;
  tcs_pkg::vec3_t          tv_a, tv_b, tv_c;
  tcs_pkg::word_t          sx_a, sy_a, qz_a;
  tcs_pkg::word_t          sx_b, sy_b, qz_b;
  tcs_pkg::word_t          sx_c, sy_c, qz_c;
  tcs_pkg::face_res_t      face_res;
  tcs_pkg::face_res_t      fdly [tcs_pkg::FACE_DELAY];
  logic [tcs_pkg::LANE_LAT-1:0] vld_sr;
  logic signed [33:0]      zsum;
  logic [32:0]             zmag;
  logic                    s56_vld;
  logic [3:0]              s56_level;
  tcs_pkg::word_t          s56_scr [6];
  logic [64:0]             s56_dprod;
  logic                    s56_dneg;
  logic [31:0]             dquo;
  tcs_pkg::word_t          depth;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && s_tready;

  assign in_a = '{x: s_tdata[67:36],   y: s_tdata[99:68],   z: s_tdata[131:100]};
  assign in_b = '{x: s_tdata[163:132], y: s_tdata[195:164], z: s_tdata[227:196]};
  assign in_c = '{x: s_tdata[259:228], y: s_tdata[291:260], z: s_tdata[323:292]};

  always_ff @(posedge clk) begin
    if (rst) begin
      proj.x_scale  <= tcs_pkg::PROJ_X_RESET;
      proj.y_scale  <= tcs_pkg::PROJ_Y_RESET;
      proj.z_scale  <= tcs_pkg::PROJ_Z_RESET;
      proj.z_offset <= tcs_pkg::PROJ_ZOFF_RESET;
      screen_w      <= tcs_pkg::SCREEN_W_RESET;
      screen_h      <= tcs_pkg::SCREEN_H_RESET;
    end else if (cfg_we) begin
      case (tcs_pkg::cfg_reg_t'(cfg_index))
        tcs_pkg::REG_PROJ_X:    proj.x_scale  <= cfg_data;
        tcs_pkg::REG_PROJ_Y:    proj.y_scale  <= cfg_data;
        tcs_pkg::REG_PROJ_Z:    proj.z_scale  <= cfg_data;
        tcs_pkg::REG_PROJ_ZOFF: proj.z_offset <= cfg_data;
        tcs_pkg::REG_SCREEN_W:  screen_w      <= cfg_data[12:0];
        tcs_pkg::REG_SCREEN_H:  screen_h      <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // identity after reset, one entry per load item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        world[i] <= (i % 5 == 0) ? tcs_pkg::ONE_Q16 : '0;
      end
    end else if (accept && (s_tuser == tcs_pkg::ACT_LOAD)) begin
      world[s_tdata[3:0]] <= s_tdata[35:4];
    end
  end

  tcs_lane u_lane_a (
    .clk(clk), .adv(adv), .vin(in_a), .world(world), .proj(proj),
    .screen_w(screen_w), .screen_h(screen_h),
    .tv(tv_a), .sx(sx_a), .sy(sy_a), .qz(qz_a)
  );

  tcs_lane u_lane_b (
    .clk(clk), .adv(adv), .vin(in_b), .world(world), .proj(proj),
    .screen_w(screen_w), .screen_h(screen_h),
    .tv(tv_b), .sx(sx_b), .sy(sy_b), .qz(qz_b)
  );

  tcs_lane u_lane_c (
    .clk(clk), .adv(adv), .vin(in_c), .world(world), .proj(proj),
    .screen_w(screen_w), .screen_h(screen_h),
    .tv(tv_c), .sx(sx_c), .sy(sy_c), .qz(qz_c)
  );

  tcs_face u_face (
    .clk(clk), .adv(adv), .v0(tv_a), .v1(tv_b), .v2(tv_c), .res(face_res)
  );

  // triangle marker follows the item down the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr <= '0;
    end else if (adv) begin
      vld_sr <= {vld_sr[tcs_pkg::LANE_LAT-2:0], accept && (s_tuser == tcs_pkg::ACT_TRI)};
    end
  end

  // cull and shade finish early, hold them until the lanes catch up
  always_ff @(posedge clk) begin
    if (adv) begin
      fdly[0] <= face_res;
      for (int i = 1; i < tcs_pkg::FACE_DELAY; i++) begin
        fdly[i] <= fdly[i-1];
      end
    end
  end

  assign zsum = 34'(qz_a) + 34'(qz_b) + 34'(qz_c);
  assign zmag = zsum[33] ? 33'(-zsum) : 33'(zsum);

  always_ff @(posedge clk) begin
    if (rst) begin
      s56_vld <= 1'b0;
    end else if (adv) begin
      s56_vld <= vld_sr[tcs_pkg::LANE_LAT-1] && fdly[tcs_pkg::FACE_DELAY-1].keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s56_level  <= fdly[tcs_pkg::FACE_DELAY-1].level;
      s56_scr[0] <= sx_a;
      s56_scr[1] <= sy_a;
      s56_scr[2] <= sx_b;
      s56_scr[3] <= sy_b;
      s56_scr[4] <= sx_c;
      s56_scr[5] <= sy_c;
      s56_dprod  <= 65'(zmag) * 65'(tcs_pkg::DIV3_MAGIC);
      s56_dneg   <= zsum[33];
    end
  end

  // mean depth truncates toward zero
  assign dquo  = 32'(s56_dprod >> tcs_pkg::DIV3_SHIFT);
  assign depth = s56_dneg ? 32'(-dquo) : dquo;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s56_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {4'b0, s56_level, depth, s56_scr[5], s56_scr[4], s56_scr[3],
                  s56_scr[2], s56_scr[1], s56_scr[0]};
    end
  end

endmodule
`default_nettype wire
